FILE: hdl/asgh_pkg.sv
// ============================================================================
// asgh_pkg
// Shared types and constants for the auto-scaled group histogram.
// ============================================================================
package asgh_pkg;

    localparam int MODE_W      = 2;
    localparam int GROUP_W     = 3;
    localparam int VALUE_W     = 16;
    localparam int BIN_IDX_W   = 9;
    localparam int SHIFT_W     = 4;
    localparam int EDGE_W      = 17;
    localparam int COUNT_W     = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd15;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_CLEAR,
        ST_WALK,
        ST_DRAIN,
        ST_BUILD_DONE,
        ST_READ
    } state_t;

endpackage

FILE: hdl/auto_scaled_group_histogram.sv
// ============================================================================
// auto_scaled_group_histogram
// Stores grouped values, then builds per-group histograms at a power-of-two
// bin width chosen from the running maximum, and answers bin reads.
// ============================================================================
// Usage. Words enter on s_axis; tuser carries the command (load, build, read).
// A load stores one value in its group and, while the block is idle, is taken
// at one word per cycle; it returns nothing. A read returns one word on m_axis
// with the bin count, the lower edge of the bin and the current shift. A build
// first halves the maximum until it fits the bin range (one step a cycle, at
// most 15), then clears the count memory, one entry a cycle, then walks every
// stored value through a three-stage read-modify-write of the count memory,
// one value a cycle with a pause at each change of group, and finally returns
// one word with the chosen shift. The value store and the count memory each
// have one write and one read port, which sets the pace of the clear and the
// walk; a repeated bin is forwarded from the last write. Builds and reads are
// handled one at a time; the next word is taken once the result of the
// previous one is in the result register, which holds its word while
// m_axis_tready is low; the block waits for it before producing the next
// result and takes no words meanwhile. Reset clears the fill counts, maximum,
// shift and handshakes; reads before the first build return zero counts.
// ============================================================================
module auto_scaled_group_histogram #(
    parameter int BIN_COUNT       = 500,
    parameter int ITEMS_PER_GROUP = 1024,
    parameter int GROUP_COUNT     = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // group [2:0], value [18:3], bin_index [27:19], zero [31:28]
    input  logic [asgh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode [1:0]
    input  logic [asgh_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // scale_shift [3:0], bin_low_edge [20:4], bin_count [31:21], max_value [47:32]
    output logic [asgh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind [0]
    output logic                              m_axis_tuser
);
    import asgh_pkg::*;

    localparam int GRP_W    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int FILL_W   = $clog2(ITEMS_PER_GROUP + 1);
    localparam int ST_DEPTH = GROUP_COUNT * ITEMS_PER_GROUP;
    localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int BN_DEPTH = GROUP_COUNT * BIN_COUNT;
    localparam int BN_AW    = $clog2(BN_DEPTH);

    // Input fields
    logic [GROUP_W-1:0]   in_group;
    logic [VALUE_W-1:0]   in_value;
    logic [BIN_IDX_W-1:0] in_bin_index;
    logic [MODE_W-1:0]    in_mode;
    logic [6:0]           in_group_ext;
    logic [GRP_W-1:0]     in_group_idx;
    logic                 in_group_ok;
    logic                 in_bin_ok;
    logic                 accept;

    assign in_group     = s_axis_tdata[2:0];
    assign in_value     = s_axis_tdata[18:3];
    assign in_bin_index = s_axis_tdata[27:19];
    assign in_mode      = s_axis_tuser;
    assign in_group_ext = {4'b0, in_group};
    assign in_group_idx = in_group_ext[GRP_W-1:0];
    assign in_group_ok  = 32'(in_group) < 32'(GROUP_COUNT);
    assign in_bin_ok    = 32'(in_bin_index) < 32'(BIN_COUNT);
    assign accept       = s_axis_tvalid && s_axis_tready;

    // Control state
    state_t               state_reg, state_next;
    logic [FILL_W-1:0]    group_fill_reg [GROUP_COUNT];
    logic [VALUE_W-1:0]   largest_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [VALUE_W-1:0]   top_reg;
    logic                 built_reg;
    logic [BN_AW-1:0]     clr_addr_reg;
    logic [GRP_W-1:0]     walk_g_reg;
    logic [FILL_W-1:0]    walk_i_reg;
    logic [ST_AW-1:0]     store_base_reg;
    logic [ST_AW-1:0]     store_addr_reg;
    logic [BN_AW-1:0]     bin_base_reg;

    // Walk pipeline
    logic                 val_valid_reg;
    logic [BN_AW-1:0]     val_base_reg;
    logic [VALUE_W-1:0]   val_rd_reg;
    logic                 bin_valid_reg;
    logic [BN_AW-1:0]     bin_addr_reg;
    logic [COUNT_W-1:0]   cnt_rd_reg;
    logic                 lw_valid_reg;
    logic [BN_AW-1:0]     lw_addr_reg;
    logic [COUNT_W-1:0]   lw_data_reg;

    // Read command
    logic                 rd_zero_reg;
    logic [BIN_IDX_W-1:0] rd_bidx_reg;

    // Output register
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic                   m_user_reg;

    // Memories
    logic [VALUE_W-1:0] value_mem [ST_DEPTH];
    logic [COUNT_W-1:0] count_mem [BN_DEPTH];

    // Control strobes
    logic               load_ok;
    logic               st_we;
    logic               st_re;
    logic               bn_re;
    logic               bn_we;
    logic               walk_wr;
    logic               out_load;
    logic               shift_step;
    logic               clr_last;
    logic               walk_more;
    logic               walk_last_group;
    logic [GRP_W-1:0]   fill_idx;
    logic [FILL_W-1:0]  fill_cur;

    // Datapath values
    logic [ST_AW-1:0]   st_waddr;
    logic [BN_AW-1:0]   rd_addr;
    logic [BN_AW-1:0]   bn_raddr;
    logic [BN_AW-1:0]   bn_waddr;
    logic [COUNT_W-1:0] bn_wdata;
    logic [VALUE_W-1:0] walk_bin_raw;
    logic [VALUE_W-1:0] walk_bin;
    logic [BN_AW-1:0]   walk_addr;
    logic [COUNT_W-1:0] cnt_cur;
    logic [COUNT_W-1:0] cnt_new;
    logic [23:0]        edge_wide;
    logic [COUNT_W-1:0] read_count;

    assign fill_idx = (state_reg == ST_IDLE) ? in_group_idx : walk_g_reg;
    assign fill_cur = group_fill_reg[fill_idx];
    assign load_ok  = in_group_ok && (fill_cur < FILL_W'(ITEMS_PER_GROUP));
    assign st_waddr = ST_AW'(in_group_idx * ITEMS_PER_GROUP) + ST_AW'(fill_cur);
    assign rd_addr  = BN_AW'(in_group_idx * BIN_COUNT) + BN_AW'(in_bin_index);

    assign shift_step      = (top_reg > VALUE_W'(BIN_COUNT)) && (shift_reg < SHIFT_MAX);
    assign clr_last        = clr_addr_reg == BN_AW'(BN_DEPTH - 1);
    assign walk_more       = walk_i_reg < fill_cur;
    assign walk_last_group = walk_g_reg == GRP_W'(GROUP_COUNT - 1);

    // Stage one of the walk: bin of the fetched value, clamped into the last bin.
    assign walk_bin_raw = val_rd_reg >> shift_reg;
    assign walk_bin     = (walk_bin_raw >= VALUE_W'(BIN_COUNT)) ?
                          VALUE_W'(BIN_COUNT - 1) : walk_bin_raw;
    assign walk_addr    = val_base_reg + BN_AW'(walk_bin);

    // Stage two: the count was read in the same cycle as the last write and
    // missed it, so a hit on that address takes the written value instead.
    assign cnt_cur = (lw_valid_reg && (lw_addr_reg == bin_addr_reg)) ? lw_data_reg : cnt_rd_reg;
    assign cnt_new = (cnt_cur < COUNT_MAX) ? cnt_cur + COUNT_W'(1) : cnt_cur;

    assign bn_raddr = (state_reg == ST_IDLE) ? rd_addr : walk_addr;
    assign bn_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : bin_addr_reg;
    assign bn_wdata = (state_reg == ST_CLEAR) ? '0 : cnt_new;

    assign edge_wide  = 24'(rd_bidx_reg) << shift_reg;
    assign read_count = rd_zero_reg ? '0 : cnt_rd_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_mode)
                        MODE_BUILD: state_next = ST_SHIFT;
                        MODE_READ:  state_next = ST_READ;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SHIFT:
            begin
                if (!shift_step)
                    state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (!walk_more && walk_last_group)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!val_valid_reg && !bin_valid_reg)
                    state_next = ST_BUILD_DONE;
            end
            ST_BUILD_DONE,
            ST_READ:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        st_we         = 1'b0;
        st_re         = 1'b0;
        bn_re         = 1'b0;
        bn_we         = 1'b0;
        walk_wr       = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                st_we = accept && (in_mode == MODE_LOAD) && load_ok;
                bn_re = accept && (in_mode == MODE_READ);
            end
            ST_CLEAR:
            begin
                bn_we = 1'b1;
            end
            ST_WALK,
            ST_DRAIN:
            begin
                st_re   = (state_reg == ST_WALK) && walk_more;
                bn_re   = val_valid_reg;
                bn_we   = bin_valid_reg;
                walk_wr = bin_valid_reg;
            end
            ST_BUILD_DONE,
            ST_READ:
            begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (st_we)
            value_mem[st_waddr] <= in_value;
        if (st_re)
            val_rd_reg <= value_mem[store_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (bn_we)
            count_mem[bn_waddr] <= bn_wdata;
        if (bn_re)
            cnt_rd_reg <= count_mem[bn_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            largest_reg   <= '0;
            shift_reg     <= '0;
            built_reg     <= 1'b0;
            val_valid_reg <= 1'b0;
            bin_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int g = 0; g < GROUP_COUNT; g++)
                group_fill_reg[g] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            val_valid_reg <= st_re;
            bin_valid_reg <= val_valid_reg;
            lw_valid_reg  <= walk_wr;
            if (st_we)
            begin
                group_fill_reg[in_group_idx] <= fill_cur + FILL_W'(1);
                if (in_value > largest_reg)
                    largest_reg <= in_value;
            end
            if (state_reg == ST_IDLE && accept && in_mode == MODE_BUILD)
                shift_reg <= '0;
            else if (state_reg == ST_SHIFT && shift_step)
                shift_reg <= shift_reg + SHIFT_W'(1);
            if (state_reg == ST_SHIFT)
                built_reg <= 1'b1;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            top_reg        <= largest_reg;
            clr_addr_reg   <= '0;
            walk_g_reg     <= '0;
            walk_i_reg     <= '0;
            store_base_reg <= '0;
            store_addr_reg <= '0;
            bin_base_reg   <= '0;
            if (accept && in_mode == MODE_READ)
            begin
                rd_zero_reg <= !(built_reg && in_group_ok && in_bin_ok);
                rd_bidx_reg <= in_bin_index;
            end
        end
        if (state_reg == ST_SHIFT && shift_step)
            top_reg <= top_reg >> 1;
        if (state_reg == ST_CLEAR)
            clr_addr_reg <= clr_addr_reg + BN_AW'(1);
        if (state_reg == ST_WALK)
        begin
            if (walk_more)
            begin
                walk_i_reg     <= walk_i_reg + FILL_W'(1);
                store_addr_reg <= store_addr_reg + ST_AW'(1);
            end
            else
            begin
                walk_g_reg     <= walk_g_reg + GRP_W'(1);
                walk_i_reg     <= '0;
                store_base_reg <= store_base_reg + ST_AW'(ITEMS_PER_GROUP);
                store_addr_reg <= store_base_reg + ST_AW'(ITEMS_PER_GROUP);
                bin_base_reg   <= bin_base_reg + BN_AW'(BIN_COUNT);
            end
        end
        if (st_re)
            val_base_reg <= bin_base_reg;
        if (val_valid_reg)
            bin_addr_reg <= walk_addr;
        if (walk_wr)
        begin
            lw_addr_reg <= bin_addr_reg;
            lw_data_reg <= cnt_new;
        end
        if (out_load)
        begin
            if (state_reg == ST_READ)
            begin
                m_user_reg <= KIND_READ;
                m_data_reg <= {largest_reg, read_count, edge_wide[EDGE_W-1:0], shift_reg};
            end
            else
            begin
                m_user_reg <= KIND_BUILD;
                m_data_reg <= {largest_reg, COUNT_W'(0), EDGE_W'(0), shift_reg};
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Stream-level check of the auto-scaled group histogram. A scoreboard class
// keeps its own copy of the stored values, fill counts, running maximum, bin
// counts and shift. Each accepted command word updates that copy, and builds
// and reads queue the result word they should return. A short directed
// sequence is followed by random traffic in three stages: small values,
// stuffing one group past its capacity, then values whose range grows until
// it spans the full value field. Both sides of the stream idle at random.
// ============================================================================
module testbench;

    import asgh_pkg::*;

    localparam int BINS   = 500;
    localparam int SLOTS  = 1024;
    localparam int GROUPS = 8;

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int HOT_GROUP  = 6;
    localparam int IDLE_LIMIT = 40000;

    typedef struct packed {
        logic               kind;
        logic [SHIFT_W-1:0] scale_shift;
        logic [EDGE_W-1:0]  low_edge;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] peak;
    } result_t;

    class histogram_board;
        logic [VALUE_W-1:0] stored [GROUPS][SLOTS];
        int unsigned        fill [GROUPS];
        logic [VALUE_W-1:0] peak;
        logic [COUNT_W-1:0] tally [GROUPS][BINS];
        logic [SHIFT_W-1:0] shift;
        result_t            due_results [$];
        int                 errors;

        function new();
            peak   = '0;
            shift  = '0;
            errors = 0;
            foreach (fill[g])
                fill[g] = 0;
            foreach (tally[g, b])
                tally[g][b] = '0;
        endfunction

        function void build_histograms();
            int unsigned top;
            int unsigned bin;
            top   = peak;
            shift = '0;
            while (top > BINS && shift < SHIFT_MAX)
            begin
                top   = top >> 1;
                shift = shift + 1'b1;
            end
            foreach (tally[g, b])
                tally[g][b] = '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                for (int i = 0; i < fill[g]; i++)
                begin
                    bin = stored[g][i] >> shift;
                    // Anything beyond the top bin is folded into it.
                    if (bin >= BINS)
                        bin = BINS - 1;
                    if (tally[g][bin] != COUNT_MAX)
                        tally[g][bin] = tally[g][bin] + 1'b1;
                end
            end
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic [GROUP_W-1:0] grp,
                                   logic [VALUE_W-1:0] val, logic [BIN_IDX_W-1:0] bin);
            result_t res;
            res = '0;
            case (mode)
                MODE_LOAD:
                begin
                    if (fill[grp] < SLOTS)
                    begin
                        stored[grp][fill[grp]] = val;
                        fill[grp] = fill[grp] + 1;
                        if (val > peak)
                            peak = val;
                    end
                end
                MODE_BUILD:
                begin
                    build_histograms();
                    res.kind        = KIND_BUILD;
                    res.scale_shift = shift;
                    res.peak        = peak;
                    due_results.push_back(res);
                end
                MODE_READ:
                begin
                    res.kind        = KIND_READ;
                    res.scale_shift = shift;
                    res.low_edge    = EDGE_W'(bin) << shift;
                    res.count       = (bin < BINS) ? tally[grp][bin] : '0;
                    res.peak        = peak;
                    due_results.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic kind, logic [OUT_TDATA_W-1:0] word);
            result_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none, got kind %0d data %h",
                         $time, kind, word);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("scale_shift", want.scale_shift, word[3:0]);
            compare_field("bin_low_edge", want.low_edge, word[20:4]);
            compare_field("bin_count", want.count, word[31:21]);
            compare_field("max_value", want.peak, word[47:32]);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [MODE_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    histogram_board board = new();
    bit             sender_rush = 1'b0;
    int             stall_left  = 0;
    int             idle_cycles = 0;

    auto_scaled_group_histogram #(
        .BIN_COUNT       (BINS),
        .ITEMS_PER_GROUP (SLOTS),
        .GROUP_COUNT     (GROUPS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: mostly ready, with short stalls and the odd long one.
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                m_axis_tready <= 1'b1;
                stall_left    <= $urandom_range(1, 20);
            end
            else if (r < 95)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(1, 3);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_command(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3],
                                   s_axis_tdata[27:19]);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tuser, m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("[auto_scaled_group_histogram] ERROR");
                $finish;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if ($urandom_range(0, 49) == 0)
            sender_rush = ~sender_rush;
        if (sender_rush)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one word at a falling edge and returns once it has been taken.
    task automatic send_word(logic [MODE_W-1:0] mode, logic [GROUP_W-1:0] grp,
                             logic [VALUE_W-1:0] val, logic [BIN_IDX_W-1:0] bin);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, bin, val, grp};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The sender stays silent while the block works through what it holds.
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
    endtask

    // One random command. Most reads aim at the bin of a value already stored,
    // so that non-zero counts are read back often.
    task automatic random_word(int load_pct, int build_pct, int hot_pct,
                               logic [VALUE_W-1:0] cap, output bit counted);
        int                   r;
        int                   pick;
        int unsigned          slot;
        int unsigned          scaled;
        logic [MODE_W-1:0]    mode;
        logic [GROUP_W-1:0]   grp;
        logic [VALUE_W-1:0]   val;
        logic [BIN_IDX_W-1:0] bin;
        r       = $urandom_range(0, 99);
        grp     = GROUP_W'($urandom_range(0, GROUPS - 1));
        bin     = BIN_IDX_W'($urandom_range(0, 511));
        pick    = $urandom_range(0, 9);
        val     = (pick == 0) ? '0 : (pick == 1) ? cap : VALUE_W'($urandom_range(0, cap));
        counted = 1'b1;
        if (r == 99)
        begin
            mode    = MODE_IGNORED;
            counted = 1'b0;
        end
        else if (r < load_pct)
        begin
            mode = MODE_LOAD;
            if ($urandom_range(0, 99) < hot_pct)
                grp = GROUP_W'(HOT_GROUP);
        end
        else if (r < load_pct + build_pct)
            mode = MODE_BUILD;
        else
        begin
            mode = MODE_READ;
            if ($urandom_range(0, 9) < 7 && board.fill[grp] > 0)
            begin
                slot   = $urandom_range(0, board.fill[grp] - 1);
                scaled = board.stored[grp][slot] >> board.shift;
                bin    = (scaled >= BINS) ? BIN_IDX_W'(BINS - 1) : BIN_IDX_W'(scaled);
            end
        end
        send_word(mode, grp, val, bin);
    endtask

    initial
    begin
        int n;
        int k;
        bit counted;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A read and a build before anything is stored.
        send_word(MODE_READ,  3'd0, 16'd0,   9'd0);
        send_word(MODE_BUILD, 3'd0, 16'd0,   9'd0);
        // A maximum of exactly the bin range: value 500 lands past the top bin.
        send_word(MODE_LOAD,  3'd0, 16'd0,   9'd0);
        send_word(MODE_LOAD,  3'd0, 16'd500, 9'd0);
        send_word(MODE_LOAD,  3'd7, 16'd499, 9'd0);
        send_word(MODE_LOAD,  3'd3, 16'd1,   9'd0);
        send_word(MODE_BUILD, 3'd0, 16'd0,   9'd0);
        send_word(MODE_READ,  3'd0, 16'd0,   9'd0);
        send_word(MODE_READ,  3'd0, 16'd0,   9'd499);
        send_word(MODE_READ,  3'd7, 16'd0,   9'd499);
        send_word(MODE_READ,  3'd3, 16'd0,   9'd1);
        // Bin indexes beyond the range read zero but still report the edge.
        send_word(MODE_READ,  3'd0, 16'd0,   9'd511);
        send_word(MODE_READ,  3'd7, 16'd0,   9'd500);
        send_word(MODE_IGNORED, 3'd7, 16'hFFFF, 9'd511);
        // A load after a build must not show until the next build.
        send_word(MODE_LOAD,  3'd1, 16'd1001, 9'd0);
        send_word(MODE_LOAD,  3'd0, 16'd2,    9'd0);
        send_word(MODE_READ,  3'd0, 16'd0,    9'd2);
        send_word(MODE_BUILD, 3'd0, 16'd0,    9'd0);
        send_word(MODE_READ,  3'd1, 16'd0,    9'd499);
        send_word(MODE_READ,  3'd0, 16'd0,    9'd250);
        send_word(MODE_READ,  3'd0, 16'd0,    9'd1);
        send_word(MODE_READ,  3'd5, 16'd0,    9'd0);
        send_word(MODE_READ,  3'd0, 16'd0,    9'd0);

        n = 0;
        while (n < 150)
        begin
            random_word(60, 5, 0, 16'd520, counted);
            n += counted;
        end

        // Hold off until the block has answered everything so far.
        wait_for_results();

        // Fill one group up and keep loading it once it is full.
        k = 0;
        while (board.fill[HOT_GROUP] < SLOTS || k < 40)
        begin
            random_word(95, 1, 97, 16'd2047, counted);
            if (board.fill[HOT_GROUP] == SLOTS)
                k++;
        end

        wait_for_results();

        // Widen the value range step by step up to the full field.
        n = 0;
        while (n < 240)
        begin
            random_word(55, 6, 0, VALUE_W'((32'd2048 << (n / 40)) - 1), counted);
            n += counted;
        end
        send_word(MODE_BUILD, 3'd0, 16'd0, 9'd0);
        send_word(MODE_READ,  3'd6, 16'hFFFF, 9'd511);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait_for_results();
        repeat (20) @(posedge clk);

        if (board.due_results.size() != 0)
        begin
            $display("%0t: result words missing, expected %0d more, got none",
                     $time, board.due_results.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("[auto_scaled_group_histogram] OK");
        else
            $display("[auto_scaled_group_histogram] ERROR");
        $finish;
    end

endmodule
